// File: rtl/core/mfa_pkg.sv
// Types and constants shared by the metaball field accumulator.
package mfa_pkg;

	localparam int CoordW = 16;
	localparam int DiffW  = 17;
	localparam int MagW   = 16;
	localparam int D2W    = 34;
	localparam int QW     = 40;
	localparam int ProdW  = MagW + QW;
	localparam int DvdW   = ProdW + 8;
	localparam int AccW   = 32;
	localparam int CntW   = 7;

	localparam logic [D2W-1:0]  MinD2       = D2W'(7);
	localparam logic [CntW-1:0] FieldDivLen = CntW'(40);
	localparam logic [CntW-1:0] NormDivLen  = CntW'(DvdW);

	typedef struct packed {
		logic signed [CoordW-1:0] vertex_x;
		logic signed [CoordW-1:0] vertex_y;
		logic signed [CoordW-1:0] vertex_z;
		logic signed [CoordW-1:0] center_x;
		logic signed [CoordW-1:0] center_y;
		logic signed [CoordW-1:0] center_z;
		logic        [CoordW-1:0] strength;
		logic                     first_sphere;
		logic                     last_sphere;
	} mfa_in_t;

	typedef struct packed {
		logic        [AccW-1:0] field_value;
		logic signed [AccW-1:0] normal_x;
		logic signed [AccW-1:0] normal_y;
		logic signed [AccW-1:0] normal_z;
		logic                   saturated;
	} mfa_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIV_LOAD,
		ST_DIVIDE,
		ST_ADD_FIELD,
		ST_PRODUCT,
		ST_ADD_NORMAL,
		ST_EMIT
	} mfa_state_t;

endpackage

// File: rtl/core/metaball_field_accumulate.sv
// Metaball field and normal accumulator with a shared multiplier and bit-serial divider.
//
//  channel | signals                        | moves
//  --------+--------------------------------+---------------------------------------
//  input   | in_valid, in_ready, in_data    | one sphere request for one vertex
//  output  | out_valid, out_ready, out_data | field and normal after the last sphere
//
// A sphere is taken in the idle state, its differences are squared and summed in the
// square state, and then come a 40-step division for the field term and three 64-step
// divisions for the normal terms, all on a single restoring divider that retires one
// quotient bit a cycle, with a load, add or product state around each. in_ready is high
// only in the idle state. A finished result waits in the output register, so the next
// sphere is taken while it stalls; only a second result waits for the first to be taken.
// Reset clears all accumulators and the clip flag.
module metaball_field_accumulate
	import mfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mfa_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output mfa_out_t out_data
);

	mfa_state_t state_q, state_d;

	logic        [1:0]      ax_q;
	logic                   last_q;
	logic        [CoordW-1:0] strength_q;
	logic        [MagW-1:0] mag_q [3];
	logic                   neg_q [3];
	logic        [D2W-1:0]  d2_q;
	logic        [ProdW-1:0] prod_q;
	logic        [QW-1:0]   q_q;
	logic        [DvdW-1:0] dvd_q;
	logic        [D2W-1:0]  rem_q;
	logic        [CntW-1:0] cnt_q;
	logic                   normal_phase_q;
	logic        [AccW-1:0] value_acc_q;
	logic signed [AccW-1:0] nacc_q [3];
	logic                   clip_q;
	logic                   out_valid_q;
	mfa_out_t               out_q;

	logic                   accept;
	logic                   emit_ok;
	logic                   emit_load;

	logic signed [DiffW-1:0] diff [3];
	logic        [MagW-1:0] mag_sel;
	logic                   neg_sel;
	logic signed [AccW-1:0] nacc_sel;
	logic        [QW-1:0]   mul_b;
	logic        [ProdW-1:0] prod_d;
	logic        [D2W:0]    rem_sh;
	logic                   rem_ge;
	logic        [QW:0]     value_sum;
	logic        [D2W-1:0]  nsum;
	logic                   t_big;
	logic                   n_over;
	logic                   n_under;
	logic signed [AccW-1:0] nacc_new;
	logic                   nclip;

	// input differences, sign and magnitude per axis
	always_comb begin
		diff[0] = DiffW'(in_data.vertex_x) - DiffW'(in_data.center_x);
		diff[1] = DiffW'(in_data.vertex_y) - DiffW'(in_data.center_y);
		diff[2] = DiffW'(in_data.vertex_z) - DiffW'(in_data.center_z);
	end

	always_comb begin
		mag_sel  = '0;
		neg_sel  = 1'b0;
		nacc_sel = '0;
		case (ax_q)
			2'd0: begin
				mag_sel  = mag_q[0];
				neg_sel  = neg_q[0];
				nacc_sel = nacc_q[0];
			end
			2'd1: begin
				mag_sel  = mag_q[1];
				neg_sel  = neg_q[1];
				nacc_sel = nacc_q[1];
			end
			2'd2: begin
				mag_sel  = mag_q[2];
				neg_sel  = neg_q[2];
				nacc_sel = nacc_q[2];
			end
			default: begin
				mag_sel  = '0;
				neg_sel  = 1'b0;
				nacc_sel = '0;
			end
		endcase
	end

	// shared multiplier: squares in the square state, magnitude times q otherwise
	assign mul_b  = (state_q == ST_SQUARE) ? QW'(mag_sel) : q_q;
	assign prod_d = ProdW'(mag_sel) * ProdW'(mul_b);

	// one restoring step of the shared divider
	assign rem_sh = {rem_q, dvd_q[DvdW-1]};
	assign rem_ge = rem_sh >= {1'b0, d2_q};

	assign value_sum = (QW+1)'(value_acc_q) + (QW+1)'(dvd_q[QW-1:0]);

	// the normal term, saturating against a signed 32-bit range
	always_comb begin
		t_big    = |dvd_q[DvdW-1:AccW];
		nsum     = D2W'(nacc_sel)
			+ (neg_sel ? -D2W'(dvd_q[AccW-1:0]) : D2W'(dvd_q[AccW-1:0]));
		n_over   = !nsum[D2W-1] && (nsum[D2W-2:AccW-1] != 2'b00);
		n_under  = nsum[D2W-1] && (nsum[D2W-2:AccW-1] != 2'b11);
		nclip    = t_big || n_over || n_under;
		if (t_big) begin
			nacc_new = neg_sel ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
		end else if (n_over) begin
			nacc_new = {1'b0, {(AccW-1){1'b1}}};
		end else if (n_under) begin
			nacc_new = {1'b1, {(AccW-1){1'b0}}};
		end else begin
			nacc_new = nsum[AccW-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_valid) state_d = ST_SQUARE;
			ST_SQUARE:     if (ax_q == 2'd3) state_d = ST_DIV_LOAD;
			ST_DIV_LOAD:   state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (cnt_q == CntW'(1)) begin
					state_d = normal_phase_q ? ST_ADD_NORMAL : ST_ADD_FIELD;
				end
			end
			ST_ADD_FIELD:  state_d = ST_PRODUCT;
			ST_PRODUCT:    state_d = ST_DIV_LOAD;
			ST_ADD_NORMAL: begin
				if (ax_q != 2'd2) begin
					state_d = ST_PRODUCT;
				end else begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT:       if (emit_ok) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_EMIT: emit_load = emit_ok;
			default: begin
				in_ready  = 1'b0;
				emit_load = 1'b0;
			end
		endcase
	end

	assign accept  = in_valid && in_ready;
	assign emit_ok = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ax_q           <= '0;
			normal_phase_q <= 1'b0;
			cnt_q          <= '0;
			value_acc_q    <= '0;
			nacc_q[0]      <= '0;
			nacc_q[1]      <= '0;
			nacc_q[2]      <= '0;
			clip_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (emit_load) out_valid_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ax_q           <= '0;
						normal_phase_q <= 1'b0;
						if (in_data.first_sphere) begin
							value_acc_q <= '0;
							nacc_q[0]   <= '0;
							nacc_q[1]   <= '0;
							nacc_q[2]   <= '0;
							clip_q      <= 1'b0;
						end
					end
				end
				ST_SQUARE: begin
					ax_q <= (ax_q == 2'd3) ? 2'd0 : ax_q + 2'd1;
				end
				ST_DIV_LOAD: begin
					cnt_q <= normal_phase_q ? NormDivLen : FieldDivLen;
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q - CntW'(1);
				end
				ST_ADD_FIELD: begin
					normal_phase_q <= 1'b1;
					if (|value_sum[QW:AccW]) begin
						value_acc_q <= '1;
						clip_q      <= 1'b1;
					end else begin
						value_acc_q <= value_sum[AccW-1:0];
					end
				end
				ST_ADD_NORMAL: begin
					case (ax_q)
						2'd0:    nacc_q[0] <= nacc_new;
						2'd1:    nacc_q[1] <= nacc_new;
						2'd2:    nacc_q[2] <= nacc_new;
						default: nacc_q[0] <= nacc_q[0];
					endcase
					if (nclip) clip_q <= 1'b1;
					if (ax_q != 2'd2) ax_q <= ax_q + 2'd1;
				end
				default: begin
					ax_q <= ax_q;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q     <= in_data.last_sphere;
			strength_q <= in_data.strength;
			d2_q       <= '0;
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= diff[i][DiffW-1];
				mag_q[i] <= diff[i][DiffW-1] ? MagW'(-diff[i]) : MagW'(diff[i]);
			end
		end
		if (state_q == ST_SQUARE) begin
			if (ax_q != 2'd3) prod_q <= prod_d;
			if (ax_q != 2'd0) d2_q <= d2_q + prod_q[D2W-1:0];
		end
		if (state_q == ST_PRODUCT) prod_q <= prod_d;
		if (state_q == ST_DIV_LOAD) begin
			rem_q <= '0;
			if (d2_q == '0) d2_q <= MinD2;
			if (normal_phase_q) begin
				dvd_q <= {prod_q, 8'b0};
			end else begin
				dvd_q <= {strength_q, {(DvdW-CoordW){1'b0}}};
			end
		end
		if (state_q == ST_DIVIDE) begin
			rem_q <= rem_ge ? D2W'(rem_sh - {1'b0, d2_q}) : rem_sh[D2W-1:0];
			dvd_q <= {dvd_q[DvdW-2:0], rem_ge};
		end
		if (state_q == ST_ADD_FIELD) q_q <= dvd_q[QW-1:0];
		if (emit_load) begin
			out_q.field_value <= value_acc_q;
			out_q.normal_x    <= nacc_q[0];
			out_q.normal_y    <= nacc_q[1];
			out_q.normal_z    <= nacc_q[2];
			out_q.saturated   <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: bench/metaball_field_accumulate_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the metaball field and normal accumulator.
module metaball_field_accumulate_tb;
	import mfa_pkg::*;

	localparam int RandomItems = 550;
	localparam int HoldCycles  = 1500;
	localparam int DrainCycles = 600;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	mfa_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	mfa_out_t out_data;

	metaball_field_accumulate DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// accumulator copy used for prediction
	logic        [AccW-1:0] field_sum;
	logic signed [AccW-1:0] normal_sum_x;
	logic signed [AccW-1:0] normal_sum_y;
	logic signed [AccW-1:0] normal_sum_z;
	logic                   clip_latched;

	mfa_out_t pending_vertices[$];
	int       error_count;
	int       requests_sent;
	int       vertices_checked;
	bit       tx_steady;
	bit       rx_steady;
	bit       hold_request;

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = ~clk;
	end

	function automatic void add_normal_term(inout logic signed [AccW-1:0] acc, input longint d,
			input logic [63:0] q, input logic [63:0] d2);
		logic [63:0] mag;
		logic [63:0] term;
		longint      sum;
		mag  = (d < 0) ? 64'(-d) : 64'(d);
		term = (mag * 64'd256 * q) / d2;
		sum  = longint'(acc) + ((d < 0) ? -longint'(term) : longint'(term));
		if (sum > longint'(32'sh7FFF_FFFF)) begin
			sum = longint'(32'sh7FFF_FFFF);
			clip_latched = 1'b1;
		end
		if (sum < -longint'(64'h8000_0000)) begin
			sum = -longint'(64'h8000_0000);
			clip_latched = 1'b1;
		end
		acc = sum[AccW-1:0];
	endfunction

	// Fold one sphere into the vertex sums; returns 1 when a vertex result is due.
	function automatic bit accumulate_sphere(input mfa_in_t s, output mfa_out_t r);
		longint      dx, dy, dz;
		logic [63:0] d2, q, v;
		if (s.first_sphere) begin
			field_sum    = '0;
			normal_sum_x = '0;
			normal_sum_y = '0;
			normal_sum_z = '0;
			clip_latched = 1'b0;
		end
		dx = longint'($signed(s.vertex_x)) - longint'($signed(s.center_x));
		dy = longint'($signed(s.vertex_y)) - longint'($signed(s.center_y));
		dz = longint'($signed(s.vertex_z)) - longint'($signed(s.center_z));
		d2 = 64'(dx * dx + dy * dy + dz * dz);
		if (d2 == 64'd0)
			d2 = 64'(MinD2);
		q = ({48'd0, s.strength} << 24) / d2;
		v = {32'd0, field_sum} + q;
		if (v > 64'h0000_0000_FFFF_FFFF) begin
			v = 64'h0000_0000_FFFF_FFFF;
			clip_latched = 1'b1;
		end
		field_sum = v[AccW-1:0];
		add_normal_term(normal_sum_x, dx, q, d2);
		add_normal_term(normal_sum_y, dy, q, d2);
		add_normal_term(normal_sum_z, dz, q, d2);
		r.field_value = field_sum;
		r.normal_x    = normal_sum_x;
		r.normal_y    = normal_sum_y;
		r.normal_z    = normal_sum_z;
		r.saturated   = clip_latched;
		return s.last_sphere;
	endfunction

	function automatic mfa_in_t make_sphere(input logic [15:0] vx, vy, vz, cx, cy, cz,
			input logic [15:0] strength, input bit first, input bit last);
		mfa_in_t s;
		s.vertex_x     = vx;
		s.vertex_y     = vy;
		s.vertex_z     = vz;
		s.center_x     = cx;
		s.center_y     = cy;
		s.center_z     = cz;
		s.strength     = strength;
		s.first_sphere = first;
		s.last_sphere  = last;
		return s;
	endfunction

	// Offer one request, hold it until taken, then predict its outcome.
	task automatic send_sphere(input mfa_in_t s);
		mfa_out_t r;
		if (!tx_steady && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
		if (accumulate_sphere(s, r))
			pending_vertices.push_back(r);
	endtask

	function automatic int field_mismatch(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic check_vertex(input mfa_out_t got);
		mfa_out_t want;
		int       bad;
		if (pending_vertices.size() == 0) begin
			$display("%0t ns: unexpected result, expected none, got %h", $time, got);
			error_count++;
			return;
		end
		want = pending_vertices.pop_front();
		vertices_checked++;
		bad = field_mismatch("field_value", want.field_value, got.field_value)
			+ field_mismatch("normal_x", want.normal_x, got.normal_x)
			+ field_mismatch("normal_y", want.normal_y, got.normal_y)
			+ field_mismatch("normal_z", want.normal_z, got.normal_z)
			+ field_mismatch("saturated", 32'(want.saturated), 32'(got.saturated));
		if (bad != 0)
			error_count++;
	endtask

	// Result side: take results, throttle ready, and serve long hold-off requests.
	initial begin : result_monitor
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_vertex(out_data);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 16);
			end
		end
	end

	// Sums start from reset, and carry on across an emit with no clear.
	task automatic test_reset_carry();
		send_sphere(make_sphere(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 1'b0, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0200, 1'b0, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'h0000, 16'h0080, 16'h0000, 16'h0000, 16'hFF80,
			16'h0100, 1'b0, 1'b1));
	endtask

	// Vertex on the centre: the distance falls back to its minimum.
	task automatic test_zero_distance();
		send_sphere(make_sphere(16'h1234, 16'hABCD, 16'h0F0F, 16'h1234, 16'hABCD, 16'h0F0F,
			16'h0001, 1'b1, 1'b1));
		send_sphere(make_sphere(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000,
			16'h0000, 1'b1, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF, 1'b1, 1'b1));
	endtask

	// Clip the field, normal x both ways, normal y up and normal z down; the flag sticks until a clear.
	task automatic test_saturation();
		send_sphere(make_sphere(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 1'b1, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
			16'hFFFF, 1'b1, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 1'b1, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 1'b0, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0040,
			16'h0010, 1'b0, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
			16'h0010, 1'b1, 1'b1));
	endtask

	task automatic test_coordinate_extremes();
		send_sphere(make_sphere(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
			16'hFFFF, 1'b1, 1'b1));
		send_sphere(make_sphere(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'hFFFF, 1'b1, 1'b1));
		send_sphere(make_sphere(16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF,
			16'h0000, 1'b1, 1'b1));
		send_sphere(make_sphere(16'hFFFF, 16'h0000, 16'h5555, 16'h0000, 16'hFFFF, 16'hAAAA,
			16'h5555, 1'b1, 1'b1));
	endtask

	// Multi-sphere vertices, repeated clears and a vertex that never emits.
	task automatic test_flag_sequences();
		send_sphere(make_sphere(16'h0200, 16'h0100, 16'hFF00, 16'h0000, 16'h0000, 16'h0000,
			16'h0400, 1'b1, 1'b0));
		send_sphere(make_sphere(16'h0200, 16'h0100, 16'hFF00, 16'h0300, 16'h0000, 16'hFE00,
			16'h0200, 1'b0, 1'b0));
		send_sphere(make_sphere(16'h0200, 16'h0100, 16'hFF00, 16'h0100, 16'h0280, 16'h0000,
			16'h0180, 1'b0, 1'b1));
		send_sphere(make_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000,
			16'hFFFF, 1'b1, 1'b0));
		send_sphere(make_sphere(16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0100, 1'b1, 1'b0));
		send_sphere(make_sphere(16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0400, 16'h0000,
			16'h0100, 1'b0, 1'b1));
	endtask

	// Stall the result side long enough for a second result to back up into the input.
	task automatic test_backpressure();
		int k;
		tx_steady    = 1'b1;
		hold_request = 1'b1;
		for (k = 0; k < 6; k++)
			send_sphere(make_sphere(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 1'b1));
		tx_steady = 1'b0;
	endtask

	task automatic test_random_vertices();
		int            sent, spheres, k, kind, mode, span;
		bit            drop_first, drop_last;
		logic [127:0]  raw;
		logic [15:0]   vx, vy, vz, cx, cy, cz, strength;
		sent = 0;
		while (sent < RandomItems) begin
			// one stretch with neither side idling
			tx_steady = (sent >= 200 && sent < 300);
			rx_steady = tx_steady;
			kind = $urandom_range(99);
			if (kind < 10) begin
				raw = {$urandom, $urandom, $urandom, $urandom};
				send_sphere(mfa_in_t'(raw[$bits(mfa_in_t)-1:0]));
				sent++;
			end else begin
				spheres    = $urandom_range(1, 6);
				drop_first = (kind < 14);
				drop_last  = (kind >= 14 && kind < 18);
				mode       = $urandom_range(2);
				if (mode == 0) begin
					vx = 16'($urandom);
					vy = 16'($urandom);
					vz = 16'($urandom);
				end else begin
					vx = 16'($urandom_range(0, 4095) - 2048);
					vy = 16'($urandom_range(0, 4095) - 2048);
					vz = 16'($urandom_range(0, 4095) - 2048);
				end
				for (k = 0; k < spheres; k++) begin
					case ($urandom_range(2))
						0: span = 4;
						1: span = 64;
						default: span = 1024;
					endcase
					if (mode == 0) begin
						cx = 16'($urandom);
						cy = 16'($urandom);
						cz = 16'($urandom);
					end else begin
						cx = vx + 16'($urandom_range(0, 2 * span) - span);
						cy = vy + 16'($urandom_range(0, 2 * span) - span);
						cz = vz + 16'($urandom_range(0, 2 * span) - span);
					end
					case ($urandom_range(9))
						0: strength = 16'h0000;
						1: strength = 16'hFFFF;
						default: strength = 16'($urandom);
					endcase
					send_sphere(make_sphere(vx, vy, vz, cx, cy, cz, strength,
						(k == 0) && !drop_first, (k == spheres - 1) && !drop_last));
					sent++;
				end
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin : timeout_guard
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : test_sequence
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		in_data          = '0;
		field_sum        = '0;
		normal_sum_x     = '0;
		normal_sum_y     = '0;
		normal_sum_z     = '0;
		clip_latched     = 1'b0;
		error_count      = 0;
		requests_sent    = 0;
		vertices_checked = 0;
		tx_steady        = 1'b0;
		rx_steady        = 1'b0;
		hold_request     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_carry();
		test_zero_distance();
		test_saturation();
		test_coordinate_extremes();
		test_flag_sequences();
		test_backpressure();
		test_random_vertices();

		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		// spheres without a last flag may still be in flight
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d sphere requests (directed, long output stall, random vertices).",
			requests_sent);
		$display("Checked %0d vertex results, %0d with mismatches.", vertices_checked,
			error_count);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
